@@ rtl/core/sha256_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sha256_pkg;

  localparam int unsigned BlockWords = 16;
  localparam int unsigned Rounds     = 64;

  // Length field starts at this byte of the final block
  localparam logic [5:0] LEN_POS = 6'd56;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef logic [BlockWords-1:0][31:0] blk_words_t;

  typedef struct packed {
    logic       last_blk;   // digest follows this block
    blk_words_t words;
  } blk_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    FS_FILL,
    FS_PAD,
    FS_PAD2
  } front_state_e;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_ROUND,
    BS_ADD,
    BS_OUT
  } back_state_e;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    big_s0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    big_s1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_s0(input logic [31:0] x);
    small_s0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_s1(input logic [31:0] x);
    small_s1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/sha256_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sha256_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 s_tvalid_i,
  output logic                s_tready_o,
  input  wire  [7:0]          s_tdata_i,
  input  wire  [0:0]          s_tuser_i,
  input  wire                 s_tlast_i,
  input  sha256_pkg::q_stat_t q_stat_i,
  output logic                push_o,
  output sha256_pkg::blk_t    blk_o
);

  sha256_pkg::front_state_e state_q, state_d;

  logic [31:0] words_q [sha256_pkg::BlockWords];
  logic [5:0]  fill_q, fill_d;
  logic [63:0] bits_q, bits_d;

  logic        accept;
  logic        has_byte;
  logic [3:0]  widx;
  logic [31:0] word_new;
  logic        fill_push;
  logic        pad_push;
  logic        pad_last;
  logic        len_clear;

  assign accept   = s_tvalid_i && s_tready_o;
  assign has_byte = s_tuser_i[0];
  assign widx     = fill_q[5:2];

  always_comb begin
    unique case (fill_q[1:0])
      2'd0:    word_new = {s_tdata_i, 24'd0};
      2'd1:    word_new = words_q[widx] | {8'd0, s_tdata_i, 16'd0};
      2'd2:    word_new = words_q[widx] | {16'd0, s_tdata_i, 8'd0};
      default: word_new = words_q[widx] | {24'd0, s_tdata_i};
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sha256_pkg::FS_FILL: begin
        if (accept && s_tlast_i) state_d = sha256_pkg::FS_PAD;
      end
      sha256_pkg::FS_PAD: begin
        if (!q_stat_i.full) begin
          state_d = (fill_q < sha256_pkg::LEN_POS) ? sha256_pkg::FS_FILL
                                                   : sha256_pkg::FS_PAD2;
        end
      end
      default: begin
        if (!q_stat_i.full) state_d = sha256_pkg::FS_FILL;
      end
    endcase
  end

  // outputs
  always_comb begin
    s_tready_o = 1'b0;
    fill_push  = 1'b0;
    pad_push   = 1'b0;
    pad_last   = 1'b0;
    len_clear  = 1'b0;
    unique case (state_q)
      sha256_pkg::FS_FILL: begin
        s_tready_o = !q_stat_i.full;
        fill_push  = accept && has_byte && (fill_q == 6'd63);
      end
      sha256_pkg::FS_PAD: begin
        pad_push  = !q_stat_i.full;
        pad_last  = fill_q < sha256_pkg::LEN_POS;
        len_clear = pad_push && pad_last;
      end
      default: begin
        pad_push  = !q_stat_i.full;
        pad_last  = 1'b1;
        len_clear = pad_push;
      end
    endcase
  end

  assign push_o = fill_push || pad_push;

  // block image: full data block, or padding over the bytes not yet filled
  always_comb begin
    blk_o.last_blk = pad_push && pad_last;
    for (int i = 0; i < int'(sha256_pkg::BlockWords); i++) begin
      if (fill_push) begin
        blk_o.words[i] = (4'(i) == widx) ? word_new : words_q[i];
      end else begin
        for (int j = 0; j < 4; j++) begin
          if (state_q == sha256_pkg::FS_PAD2) begin
            blk_o.words[i][31-8*j -: 8] = 8'd0;
          end else if (6'(i*4+j) < fill_q) begin
            blk_o.words[i][31-8*j -: 8] = words_q[i][31-8*j -: 8];
          end else if (6'(i*4+j) == fill_q) begin
            blk_o.words[i][31-8*j -: 8] = sha256_pkg::PAD_BYTE;
          end else begin
            blk_o.words[i][31-8*j -: 8] = 8'd0;
          end
        end
      end
    end
    if (pad_last && !fill_push) begin
      blk_o.words[14] = bits_q[63:32];
      blk_o.words[15] = bits_q[31:0];
    end
  end

  always_comb begin
    fill_d = fill_q;
    bits_d = bits_q;
    if (accept && has_byte) begin
      fill_d = fill_q + 6'd1;
      bits_d = bits_q + 64'd8;
    end
    if (len_clear) begin
      fill_d = '0;
      bits_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha256_pkg::FS_FILL;
      fill_q  <= '0;
      bits_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      bits_q  <= bits_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && has_byte) words_q[widx] <= word_new;
  end

endmodule

`default_nettype wire

@@ rtl/core/sha256_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sha256_queue (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  sha256_pkg::blk_t    push_blk_i,
  input  wire                 pop_i,
  output sha256_pkg::blk_t    pop_blk_o,
  output sha256_pkg::q_stat_t stat_o
);

  sha256_pkg::blk_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign stat_o.full  = cnt_q == 2'd2;
  assign stat_o.empty = cnt_q == 2'd0;
  assign pop_blk_o    = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i)  rd_q <= !rd_q;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_blk_i;
  end

endmodule

`default_nettype wire

@@ rtl/core/sha256_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sha256_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  sha256_pkg::q_stat_t q_stat_i,
  input  sha256_pkg::blk_t    blk_i,
  output logic                pop_o,
  output logic                m_tvalid_o,
  input  wire                 m_tready_i,
  output logic [63:0]         m_tdata_o,
  output logic [1:0]          m_tuser_o,
  output logic                m_tlast_o
);

  sha256_pkg::back_state_e state_q, state_d;

  logic [31:0] chain_q [8];
  logic [31:0] v_q [8];
  logic [31:0] win_q [sha256_pkg::BlockWords];
  logic [5:0]  rnd_q;
  logic [1:0]  oidx_q;
  logic        last_q;

  logic [31:0] t1, t2, ch, maj, w_next;
  logic        out_beat;

  assign out_beat = m_tvalid_o && m_tready_i;

  // one round and one schedule step
  always_comb begin
    ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t1  = v_q[7] + sha256_pkg::big_s1(v_q[4]) + ch + sha256_pkg::ROUND_K[rnd_q] + win_q[0];
    t2  = sha256_pkg::big_s0(v_q[0]) + maj;
    w_next = sha256_pkg::small_s1(win_q[14]) + win_q[9]
           + sha256_pkg::small_s0(win_q[1]) + win_q[0];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sha256_pkg::BS_IDLE:  if (!q_stat_i.empty) state_d = sha256_pkg::BS_ROUND;
      sha256_pkg::BS_ROUND: if (rnd_q == 6'(sha256_pkg::Rounds - 1)) state_d = sha256_pkg::BS_ADD;
      sha256_pkg::BS_ADD:   state_d = last_q ? sha256_pkg::BS_OUT : sha256_pkg::BS_IDLE;
      default:              if (out_beat && oidx_q == 2'd3) state_d = sha256_pkg::BS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop_o      = 1'b0;
    m_tvalid_o = 1'b0;
    unique case (state_q)
      sha256_pkg::BS_IDLE: pop_o      = !q_stat_i.empty;
      sha256_pkg::BS_OUT:  m_tvalid_o = 1'b1;
      default: ;
    endcase
  end

  assign m_tdata_o = {chain_q[{oidx_q, 1'b0}], chain_q[{oidx_q, 1'b1}]};
  assign m_tuser_o = oidx_q;
  assign m_tlast_o = oidx_q == 2'd3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha256_pkg::BS_IDLE;
      rnd_q   <= '0;
      oidx_q  <= '0;
      last_q  <= 1'b0;
      for (int i = 0; i < 8; i++) chain_q[i] <= sha256_pkg::INIT_H[i];
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        rnd_q  <= '0;
        last_q <= blk_i.last_blk;
      end else if (state_q == sha256_pkg::BS_ROUND) begin
        rnd_q <= rnd_q + 6'd1;
      end
      if (state_q == sha256_pkg::BS_ADD) begin
        for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + v_q[i];
      end
      if (out_beat) begin
        oidx_q <= oidx_q + 2'd1;
        // digest delivered: next message starts from the initial values
        if (oidx_q == 2'd3) begin
          for (int i = 0; i < 8; i++) chain_q[i] <= sha256_pkg::INIT_H[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      for (int i = 0; i < 8; i++) v_q[i] <= chain_q[i];
      for (int i = 0; i < int'(sha256_pkg::BlockWords); i++) win_q[i] <= blk_i.words[i];
    end else if (state_q == sha256_pkg::BS_ROUND) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
      for (int i = 0; i < int'(sha256_pkg::BlockWords) - 1; i++) win_q[i] <= win_q[i+1];
      win_q[sha256_pkg::BlockWords-1] <= w_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sha256_hash.sv @@
`timescale 1ns / 1ps
`default_nettype none

// SHA-256 over a byte stream.
// Input channel (s_*): one beat per item. tdata = message byte, tuser[0] = byte
// present, tlast = end of message. A beat with tlast and no byte ends the
// message without adding data (an empty message is a single such beat).
// Output channel (m_*): four beats per message, digest most significant first;
// tuser = quarter index, tlast on the fourth beat.
// Throughput: one byte per cycle while a block fills and the queue has room.
// Each 64-byte block passes the compression engine as load, 64 rounds and
// chain add, and a two-block queue lets filling of the next block overlap
// those rounds. After the end beat the front pushes the padded block, and the
// first digest beat is offered after load, 64 rounds and chain add of the
// final block, which comes after a second block when padding spills into one,
// and after any blocks still queued ahead.
// Reset puts the chaining value at the initial hash, clears the byte and bit
// counts and empties the queue. While m_tready is low the digest beat holds;
// the front keeps taking bytes until the queue fills, then drops s_tready.
module sha256_hash (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_tvalid_i,
  output logic        s_tready_o,
  input  wire  [7:0]  s_tdata_i,   // [7:0] data_byte
  input  wire  [0:0]  s_tuser_i,   // [0] has_byte
  input  wire         s_tlast_i,   // end_of_message
  output logic        m_tvalid_o,
  input  wire         m_tready_i,
  output logic [63:0] m_tdata_o,   // [63:0] digest_word
  output logic [1:0]  m_tuser_o,   // [1:0] word_index
  output logic        m_tlast_o    // last_word
);

  sha256_pkg::q_stat_t q_stat;
  sha256_pkg::blk_t    push_blk;
  sha256_pkg::blk_t    pop_blk;
  logic                push;
  logic                pop;

  // front: byte packing, padding, length field
  sha256_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .s_tlast_i  (s_tlast_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .blk_o      (push_blk)
  );

  // two complete blocks of slack between front and engine
  sha256_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_blk_i (push_blk),
    .pop_i      (pop),
    .pop_blk_o  (pop_blk),
    .stat_o     (q_stat)
  );

  // back: one round per cycle, digest readout
  sha256_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_stat_i   (q_stat),
    .blk_i      (pop_blk),
    .pop_o      (pop),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .m_tlast_o  (m_tlast_o)
  );

endmodule

`default_nettype wire

@@ rtl/core/sha256_hash_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sha256_hash_chk (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_tvalid_i,
  input wire        s_tready_o,
  input wire        s_tlast_i,
  input wire        m_tvalid_o,
  input wire        m_tready_i,
  input wire [63:0] m_tdata_o,
  input wire [1:0]  m_tuser_o,
  input wire        m_tlast_o
);

  // tlast marks exactly the fourth quarter
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> (m_tlast_o == (m_tuser_o == 2'd3)))
    else $error("tlast does not match quarter index");

  // digest quarters follow one another without a gap, in order
  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && m_tready_i && !m_tlast_o) |=>
      (m_tvalid_o && m_tuser_o == 2'($past(m_tuser_o) + 2'd1)))
    else $error("digest quarter out of sequence");

  // a stalled beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && !m_tready_i) |=> (m_tvalid_o && $stable(m_tdata_o)
                                     && $stable(m_tuser_o)))
    else $error("stalled digest beat changed");

  // no digest beat is offered while reset is applied
  a_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !m_tvalid_o)
    else $error("digest beat offered in reset");

  // an accepted end beat is followed by a padding cycle with input closed
  a_pad_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o && s_tlast_i) |=> !s_tready_o)
    else $error("input open right after end of message");

endmodule

bind sha256_hash sha256_hash_chk u_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_tvalid_i),
  .s_tready_o (s_tready_o),
  .s_tlast_i  (s_tlast_i),
  .m_tvalid_o (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_o  (m_tdata_o),
  .m_tuser_o  (m_tuser_o),
  .m_tlast_o  (m_tlast_o)
);

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  // Round constants and initial hash, kept locally for the digest predictor
  localparam bit [31:0] RK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  localparam bit [31:0] IV_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam bit [7:0] PAD_MARK    = 8'h80;
  localparam int       LEN_OFFSET  = 56;    // byte where the bit count starts
  localparam int       HOLD_CYCLES = 2000;  // long receiver hold-off
  localparam int       TAIL_CYCLES = 400;   // idle tail after the last digest
  localparam int       RAND_ITEMS  = 100;   // beat budget for the whole run

  typedef struct packed {
    logic [63:0] word;
    logic [1:0]  quarter;
    logic        last;
  } digest_word_t;

  // Digest predictor plus the queue of digest words still owed by the block
  class digest_board;
    bit [31:0]    chain_h [8];
    bit [31:0]    blk_w [16];
    int           fill;
    bit [63:0]    msg_bits;
    digest_word_t expected_words [$];
    int           errors;
    int           words_seen;
    int           msgs_done;

    function new();
      errors     = 0;
      words_seen = 0;
      msgs_done  = 0;
      restart();
    endfunction

    function void restart();
      foreach (chain_h[i]) chain_h[i] = IV_H[i];
      fill     = 0;
      msg_bits = '0;
    endfunction

    function bit [31:0] rotr(bit [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      bit [31:0] w [64];
      bit [31:0] v [8];
      bit [31:0] t1, t2;
      for (int i = 0; i < 16; i++) w[i] = blk_w[i];
      for (int i = 16; i < 64; i++) begin
        w[i] = (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
             + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
      end
      foreach (v[i]) v[i] = chain_h[i];
      for (int i = 0; i < 64; i++) begin
        t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RK[i] + w[i];
        t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      foreach (chain_h[i]) chain_h[i] = chain_h[i] + v[i];
    endfunction

    // big-endian placement; first byte of a word overwrites it whole
    function void push_byte(bit [7:0] b);
      int p;
      p = fill;
      if (p % 4 == 0) blk_w[p/4] = {b, 24'h0};
      else blk_w[p/4][8*(3 - p%4) +: 8] = b;
      p++;
      if (p == 64) begin
        compress();
        p = 0;
      end
      fill = p;
    endfunction

    // one accepted input beat
    function void note_beat(bit [7:0] b, bit has, bit last);
      bit [63:0]    bits;
      digest_word_t dw;
      if (has) begin
        push_byte(b);
        msg_bits += 64'd8;
      end
      if (!last) return;
      bits = msg_bits;
      push_byte(PAD_MARK);
      if (fill > LEN_OFFSET)
        while (fill != 0) push_byte(8'h00);
      while (fill != LEN_OFFSET) push_byte(8'h00);
      blk_w[14] = bits[63:32];
      blk_w[15] = bits[31:0];
      compress();
      for (int k = 0; k < 4; k++) begin
        dw.word    = {chain_h[2*k], chain_h[2*k+1]};
        dw.quarter = k[1:0];
        dw.last    = (k == 3);
        expected_words.insert(expected_words.size(), dw);
      end
      msgs_done++;
      restart();
    endfunction

    function void check_word(logic [63:0] word, logic [1:0] quarter, logic last);
      digest_word_t dw;
      words_seen++;
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected digest beat word=%h quarter=%0d last=%b",
                 $time, word, quarter, last);
        return;
      end
      dw = expected_words.pop_front();
      if (word !== dw.word) begin
        errors++;
        $display("%0t: digest word mismatch expected=%h actual=%h", $time, dw.word, word);
      end
      if (quarter !== dw.quarter) begin
        errors++;
        $display("%0t: quarter mismatch expected=%0d actual=%0d", $time, dw.quarter, quarter);
      end
      if (last !== dw.last) begin
        errors++;
        $display("%0t: tlast mismatch expected=%b actual=%b", $time, dw.last, last);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic [0:0]  s_tuser = 1'b0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  logic        hold_req = 1'b0;   // stimulus asks the receiver for a long hold-off
  int          burst_left = 0;    // beats left in the current sender burst
  int          items = 0;         // beats carrying a byte or an end
  digest_board board = new();

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  sha256_hash DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tready_o (s_tready),
    .s_tdata_i  (s_tdata),    // [7:0] data_byte
    .s_tuser_i  (s_tuser),    // [0] has_byte
    .s_tlast_i  (s_tlast),    // end_of_message
    .m_tvalid_o (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_o  (m_tdata),    // [63:0] digest_word
    .m_tuser_o  (m_tuser),    // [1:0] word_index
    .m_tlast_o  (m_tlast)     // last_word
  );

  // Offer one beat and hold it until accepted. Handshake signals are read
  // right after the edge, i.e. the values the block saw at that edge.
  // Bursts of random length are followed by idle gaps; now and then a long
  // burst gives a stretch with no idling at all.
  task automatic send_beat(input logic [7:0] b, input logic has, input logic last);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= has;
    s_tlast  <= last;
    do @(posedge clk_i); while (!s_tready);
    board.note_beat(b, has, last);
    if (has || last) items++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(0, 15);
    end
  endtask

  // Message of len random bytes. The end rides on the last byte unless
  // bare_end is set (or the message is empty), then a byte-less end follows.
  // About one beat in ten ahead of a byte is noise: no byte, no end.
  task automatic send_message(input int len, input bit bare_end);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_beat(8'($urandom_range(0, 255)), 1'b1, (i == len - 1) && !bare_end);
    end
    if (bare_end || len == 0)
      send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // Sender stops and waits for every owed digest word
  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (board.expected_words.size() != 0) @(posedge clk_i);
  endtask

  // Mostly short messages; the rest sit on the padding edges: 55 still fits
  // one block, 56, 57, 62 and 63 spill the length into a second block, 64 and
  // 65 fill a whole block ahead of the padding.
  function automatic int pick_len();
    if ($urandom_range(0, 99) < 85) return int'($urandom_range(0, 10));
    case ($urandom_range(0, 6))
      0: return 55;
      1: return 56;
      2: return 57;
      3: return 62;
      4: return 63;
      5: return 64;
      default: return 65;
    endcase
  endfunction

  // Receiver: checks each accepted digest beat, then picks tready for the
  // next edge. The stall pattern rotates with rx_cycle between always
  // ready, a fixed 4-of-5 duty, coin flips and 1-of-3. A hold-off request
  // drops tready for the HOLD_CYCLES hold-off, counted down in stall_left.
  initial begin : receiver
    int rx_cycle;
    int stall_left;
    rx_cycle   = 0;
    stall_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (m_tvalid && m_tready) board.check_word(m_tdata, m_tuser, m_tlast);
      rx_cycle++;
      if (hold_req) begin
        hold_req   <= 1'b0;
        m_tready   <= 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        case ((rx_cycle / 97) % 4)
          0: m_tready <= 1'b1;
          1: m_tready <= (rx_cycle % 5) != 0;
          2: m_tready <= 1'($urandom_range(0, 1));
          default: m_tready <= (rx_cycle % 3) == 0;
        endcase
      end
    end
  end

  // Main stimulus
  initial begin : stimulus
    int rand_msgs;
    bit mid_drained;
    rand_msgs   = 0;
    mid_drained = 1'b0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty message, "abc", all-ones byte closed by a bare end,
    // a noise beat, zero byte with end, and a byte equal to the pad marker.
    send_beat(8'ha5, 1'b0, 1'b1);
    send_beat(8'h61, 1'b1, 1'b0);
    send_beat(8'h62, 1'b1, 1'b0);
    send_beat(8'h63, 1'b1, 1'b1);
    send_beat(8'hff, 1'b1, 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'h5a, 1'b0, 1'b0);
    send_beat(8'h00, 1'b1, 1'b1);
    send_beat(PAD_MARK, 1'b1, 1'b1);
    wait_drain();

    // Back-pressure: receiver holds off on the first digest while two more
    // padded blocks fill the queue (the 57-byte one spills its length), so
    // the front stalls in padding and s_tready stays low.
    hold_req <= 1'b1;
    send_message(3, 1'b0);
    send_message(2, 1'b0);
    send_message(57, 1'b0);
    send_message(4, 1'b1);

    // Random messages up to the beat budget; one full drain early on
    while (items < RAND_ITEMS) begin
      send_message(pick_len(), $urandom_range(0, 3) == 0);
      rand_msgs++;
      if (!mid_drained && rand_msgs == 3) begin
        wait_drain();
        mid_drained = 1'b1;
      end
    end

    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("run covered %0d messages over %0d beats: empty, bare ends, noise, padding",
             board.msgs_done, items);
    $display("spill into a second block, %0d digest beats checked, %0d-cycle hold-off",
             board.words_seen, HOLD_CYCLES);
    if (board.errors == 0 && board.expected_words.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #10_000_000;
    $display("%0t: timeout with %0d digest beats outstanding", $time,
             board.expected_words.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/sha256_pkg.sv
rtl/core/sha256_front.sv
rtl/core/sha256_queue.sv
rtl/core/sha256_back.sv
rtl/core/sha256_hash.sv
rtl/core/sha256_hash_chk.sv
tb/tb_top.sv
